### hw/rtl/acucs_pkg.sv
package acucs_pkg;

    // Sizing
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int QUEUE_DEPTH     = 4;

    // Byte codes
    localparam logic [7:0] ESC_BYTE     = 8'h1B;
    localparam logic [7:0] OPEN_BRACKET = 8'h5B;
    localparam logic [7:0] SEMICOLON    = 8'h3B;
    localparam logic [7:0] DIGIT_ZERO   = 8'h30;
    localparam logic [7:0] DIGIT_NINE   = 8'h39;

    // SGR numbers
    localparam logic [6:0] COLOUR_DEFAULT = 7'd0;
    localparam logic [6:0] FG_LOW_FIRST   = 7'd30;
    localparam logic [6:0] FG_LOW_LAST    = 7'd37;
    localparam logic [6:0] FG_DEFAULT     = 7'd39;
    localparam logic [6:0] FG_HIGH_FIRST  = 7'd90;
    localparam logic [6:0] FG_HIGH_LAST   = 7'd97;
    localparam logic [6:0] SGR_NORMAL     = 7'd22;
    localparam logic [6:0] NUM_SAT        = 7'd100;

    // Result kinds
    localparam logic KIND_CELL    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_SEQ,
        MODE_CELL
    } t_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_row_end;
        logic       new_picture;
    } t_item;

    typedef struct packed {
        logic        item_kind;
        logic [31:0] cell_bytes;
        logic [2:0]  cell_length;
        logic [6:0]  cell_colour;
        logic [6:0]  cell_column;
        logic [7:0]  row_cell_count;
        logic [7:0]  widest_row;
        logic        colour_seen;
        logic        last_result;
    } t_result;

    // Results of one input transaction: one or two
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_job;

    function automatic logic is_colour_code(input logic [6:0] n);
        return (n >= FG_LOW_FIRST && n <= FG_LOW_LAST) || n == FG_DEFAULT ||
               (n >= FG_HIGH_FIRST && n <= FG_HIGH_LAST);
    endfunction

    // UTF-8 sequence length from the lead byte; malformed leads count as one
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        priority if (b[7] == 1'b0) len = 3'd1;
        else if (b[7:5] == 3'b110) len = 3'd2;
        else if (b[7:4] == 4'b1110) len = 3'd3;
        else if (b[7:3] == 5'b11110) len = 3'd4;
        else len = 3'd1;
        return len;
    endfunction

endpackage

### hw/rtl/acucs_if.sv
interface acucs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_row_end;
    logic       new_picture;

    modport source (output valid, text_byte, is_row_end, new_picture, input ready);
    modport sink   (input valid, text_byte, is_row_end, new_picture, output ready);
endinterface

interface acucs_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [31:0] cell_bytes;
    logic [2:0]  cell_length;
    logic [6:0]  cell_colour;
    logic [6:0]  cell_column;
    logic [7:0]  row_cell_count;
    logic [7:0]  widest_row;
    logic        colour_seen;
    logic        last_result;

    modport source (output valid, item_kind, cell_bytes, cell_length, cell_colour,
                    cell_column, row_cell_count, widest_row, colour_seen, last_result,
                    input ready);
    modport sink   (input valid, item_kind, cell_bytes, cell_length, cell_colour,
                    cell_column, row_cell_count, widest_row, colour_seen, last_result,
                    output ready);
endinterface

### hw/rtl/acucs_front.sv
module acucs_front #(
    parameter int MAX_COLUMNS = acucs_pkg::MAX_COLUMNS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  acucs_pkg::t_item i_item,
    output logic             o_ready,
    input  logic             i_q_ready,
    output logic             o_push,
    output acucs_pkg::t_job  o_job
);
    import acucs_pkg::*;

    localparam int ColW = $clog2(MAX_COLUMNS + 1);

    t_mode            r_mode, n_mode;
    logic [6:0]       r_num, n_num;
    logic             r_num_present, n_num_present;
    logic [6:0]       r_colour, n_colour;
    logic [ColW-1:0]  r_column, n_column;
    logic [31:0]      r_partial, n_partial;
    logic [2:0]       r_expected, n_expected;
    logic [2:0]       r_received, n_received;
    logic [ColW-1:0]  r_widest, n_widest;
    logic             r_flag, n_flag;

    logic             fire;
    logic [7:0]       b;
    logic [ColW-1:0]  col_inc;
    logic             col_ok;
    logic [ColW-1:0]  tb_col;
    logic [ColW-1:0]  tb_col_inc;
    logic             tb_ok;
    logic [2:0]       lead;
    logic             is_digit;
    logic [9:0]       acc_wide;
    logic [6:0]       num_digit;
    logic [6:0]       close_colour;
    logic [6:0]       semi_colour;
    logic [2:0]       cell_rec;
    logic [31:0]      cell_merged;
    logic             do_text;
    logic             have_first;
    logic [ColW-1:0]  sum_col;
    logic [ColW-1:0]  widest_base;
    t_result          res;

    function automatic t_result mk_cell(input logic [31:0] bytes, input logic [2:0] len,
                                        input logic [6:0] colour,
                                        input logic [ColW-1:0] col);
        t_result r;
        r             = '0;
        r.item_kind   = KIND_CELL;
        r.cell_bytes  = bytes;
        r.cell_length = len;
        r.cell_colour = colour;
        r.cell_column = 7'(col);
        return r;
    endfunction

    assign fire    = i_valid && i_q_ready;
    assign o_ready = i_q_ready;
    assign b       = i_item.text_byte;

    // Column bookkeeping; a text byte after a lone escape lands one column on
    assign col_inc    = r_column + ColW'(1);
    assign col_ok     = r_column < ColW'(MAX_COLUMNS);
    assign tb_col     = (r_mode == MODE_ESC) ? col_inc : r_column;
    assign tb_col_inc = tb_col + ColW'(1);
    assign tb_ok      = tb_col < ColW'(MAX_COLUMNS);
    assign lead       = lead_length(b);

    // Number accumulation: n*10 + d, saturating
    assign is_digit  = (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
    assign acc_wide  = 10'({r_num, 3'b000}) + 10'({r_num, 1'b0}) + 10'(b[3:0]);
    assign num_digit = (acc_wide > 10'(NUM_SAT)) ? NUM_SAT : acc_wide[6:0];

    // Colour after a separator or after the closing byte
    always_comb begin
        semi_colour  = r_colour;
        close_colour = r_colour;
        if (r_num_present) begin
            if (is_colour_code(r_num)) begin
                semi_colour  = r_num;
                close_colour = r_num;
            end else begin
                if (r_num == COLOUR_DEFAULT || r_num == SGR_NORMAL) semi_colour = COLOUR_DEFAULT;
                if (r_num == COLOUR_DEFAULT) close_colour = COLOUR_DEFAULT;
            end
        end
    end

    // Continuation byte folded into the partial cell
    assign cell_rec    = (r_received < 3'd4) ? r_received + 3'd1 : r_received;
    assign cell_merged = (r_received < 3'd4) ?
                         (r_partial | (32'(b) << {r_received[1:0], 3'b000})) : r_partial;

    assign do_text = fire && !i_item.is_row_end && col_ok &&
                     ((r_mode == MODE_TEXT) ||
                      (r_mode == MODE_ESC && b != OPEN_BRACKET && tb_ok));

    // Classify the transaction, update parser state and build its results
    always_comb begin
        n_mode        = r_mode;
        n_num         = r_num;
        n_num_present = r_num_present;
        n_colour      = r_colour;
        n_column      = r_column;
        n_partial     = r_partial;
        n_expected    = r_expected;
        n_received    = r_received;
        n_flag        = r_flag;
        widest_base   = (fire && i_item.new_picture) ? '0 : r_widest;
        n_widest      = widest_base;
        sum_col       = r_column;
        o_job         = '0;
        have_first    = 1'b0;
        res           = '0;

        if (fire && !i_item.is_row_end && col_ok) begin
            unique case (r_mode)
                MODE_ESC: begin
                    if (b == OPEN_BRACKET) begin
                        n_mode        = MODE_SEQ;
                        n_num         = '0;
                        n_num_present = 1'b0;
                    end else begin
                        o_job.first = mk_cell(32'(ESC_BYTE), 3'd1, r_colour, r_column);
                        have_first  = 1'b1;
                        n_column    = col_inc;
                        n_mode      = MODE_TEXT;
                        n_partial   = '0;
                        n_expected  = '0;
                        n_received  = '0;
                    end
                end
                MODE_SEQ: begin
                    if (is_digit) begin
                        n_num         = num_digit;
                        n_num_present = 1'b1;
                    end else if (b == SEMICOLON) begin
                        n_colour      = semi_colour;
                        n_num         = '0;
                        n_num_present = 1'b0;
                    end else begin
                        n_colour      = close_colour;
                        n_flag        = r_flag | (close_colour != COLOUR_DEFAULT);
                        n_num         = '0;
                        n_num_present = 1'b0;
                        n_mode        = MODE_TEXT;
                    end
                end
                MODE_CELL: begin
                    n_partial  = cell_merged;
                    n_received = cell_rec;
                    if (cell_rec >= r_expected) begin
                        o_job.first = mk_cell(cell_merged, cell_rec, r_colour, r_column);
                        have_first  = 1'b1;
                        n_column    = col_inc;
                        n_mode      = MODE_TEXT;
                        n_partial   = '0;
                        n_expected  = '0;
                        n_received  = '0;
                    end
                end
                MODE_TEXT: begin
                end
            endcase
        end

        // Plain text byte, also the byte that follows a lone escape
        if (do_text) begin
            if (b == ESC_BYTE) begin
                n_mode = MODE_ESC;
            end else if (lead == 3'd1) begin
                res        = mk_cell(32'(b), 3'd1, r_colour, tb_col);
                n_column   = tb_col_inc;
                n_mode     = MODE_TEXT;
                n_partial  = '0;
                n_expected = '0;
                n_received = '0;
                if (!have_first) begin
                    o_job.first = res;
                    have_first  = 1'b1;
                end else begin
                    o_job.second = res;
                    o_job.two    = 1'b1;
                end
            end else begin
                n_mode     = MODE_CELL;
                n_partial  = 32'(b);
                n_received = 3'd1;
                n_expected = lead;
            end
        end

        // Row end: flush the open cell or sequence, then the summary
        if (fire && i_item.is_row_end) begin
            unique case (r_mode)
                MODE_ESC: begin
                    o_job.first = mk_cell(32'(ESC_BYTE), 3'd1, r_colour, r_column);
                    have_first  = 1'b1;
                    sum_col     = col_inc;
                end
                MODE_CELL: begin
                    o_job.first = mk_cell(r_partial, r_received, r_colour, r_column);
                    have_first  = 1'b1;
                    sum_col     = col_inc;
                end
                MODE_SEQ: begin
                    n_flag = r_flag | (close_colour != COLOUR_DEFAULT);
                end
                MODE_TEXT: begin
                end
            endcase
            n_widest             = (sum_col > widest_base) ? sum_col : widest_base;
            res                  = '0;
            res.item_kind        = KIND_SUMMARY;
            res.row_cell_count   = 8'(sum_col);
            res.widest_row       = 8'(n_widest);
            res.colour_seen      = n_flag;
            if (!have_first) begin
                o_job.first = res;
                have_first  = 1'b1;
            end else begin
                o_job.second = res;
                o_job.two    = 1'b1;
            end
            n_mode        = MODE_TEXT;
            n_num         = '0;
            n_num_present = 1'b0;
            n_colour      = COLOUR_DEFAULT;
            n_column      = '0;
            n_partial     = '0;
            n_expected    = '0;
            n_received    = '0;
        end

        o_push = fire && have_first;
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_TEXT;
            r_num         <= '0;
            r_num_present <= 1'b0;
            r_colour      <= COLOUR_DEFAULT;
            r_column      <= '0;
            r_partial     <= '0;
            r_expected    <= '0;
            r_received    <= '0;
            r_widest      <= '0;
            r_flag        <= 1'b0;
        end else if (fire) begin
            r_mode        <= n_mode;
            r_num         <= n_num;
            r_num_present <= n_num_present;
            r_colour      <= n_colour;
            r_column      <= n_column;
            r_partial     <= n_partial;
            r_expected    <= n_expected;
            r_received    <= n_received;
            r_widest      <= n_widest;
            r_flag        <= n_flag;
        end
    end

endmodule

### hw/rtl/acucs_queue.sv
module acucs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acucs_pkg::t_job i_job,
    output logic            o_ready,
    output logic            o_valid,
    output acucs_pkg::t_job o_job,
    input  logic            i_pop
);
    import acucs_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;

    assign o_ready = r_count != CntW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PtrW'(1);
        end
        if (i_push && !i_pop) n_count = r_count + CntW'(1);
        else if (!i_push && i_pop) n_count = r_count - CntW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Hold job entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

### hw/rtl/acucs_back.sv
module acucs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  acucs_pkg::t_job    i_job,
    output logic               o_pop,
    output logic               o_valid,
    output acucs_pkg::t_result o_result,
    input  logic               i_ready
);
    import acucs_pkg::*;

    logic    r_valid, n_valid;
    logic    r_sub, n_sub;
    t_result r_res;
    t_result next_res;
    logic    load;
    logic    is_last;

    assign o_valid  = r_valid;
    assign o_result = r_res;

    // Pick the next result of the head job
    assign load    = i_q_valid && (!r_valid || i_ready);
    assign is_last = !i_job.two || r_sub;
    assign o_pop   = load && is_last;

    always_comb begin
        next_res             = r_sub ? i_job.second : i_job.first;
        next_res.last_result = is_last;
        n_valid              = r_valid;
        n_sub                = r_sub;
        if (load) begin
            n_valid = 1'b1;
            n_sub   = !is_last;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) r_res <= next_res;
    end

endmodule

### hw/rtl/ansi_color_utf8_cell_splitter_top.sv
// Results pass through the job queue and then the output register to the output port.
// One input transaction per cycle while the job queue has room; the output port moves one
//   result per cycle while the sink is ready, so an input with two results takes two transfers.
// A four-entry job queue between parser and output lets input run on during output stalls.
// Reset (synchronous, active low) clears parser state, widest row, colour flag, queue pointers
//   and the output valid flag at once; no clearing pass is needed.
module ansi_color_utf8_cell_splitter_top #(
    parameter int MAX_COLUMNS = acucs_pkg::MAX_COLUMNS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acucs_in_if.sink    i_in,
    acucs_out_if.source o_out
);
    import acucs_pkg::*;

    t_item   item;
    t_job    push_job;
    t_job    head_job;
    t_result res;
    logic    push;
    logic    q_ready;
    logic    q_valid;
    logic    pop;
    logic    out_valid;

    assign item.text_byte   = i_in.text_byte;
    assign item.is_row_end  = i_in.is_row_end;
    assign item.new_picture = i_in.new_picture;

    acucs_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (item),
        .o_ready   (i_in.ready),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (push_job)
    );

    acucs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    acucs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_valid   (out_valid),
        .o_result  (res),
        .i_ready   (o_out.ready)
    );

    assign o_out.valid          = out_valid;
    assign o_out.item_kind      = res.item_kind;
    assign o_out.cell_bytes     = res.cell_bytes;
    assign o_out.cell_length    = res.cell_length;
    assign o_out.cell_colour    = res.cell_colour;
    assign o_out.cell_column    = res.cell_column;
    assign o_out.row_cell_count = res.row_cell_count;
    assign o_out.widest_row     = res.widest_row;
    assign o_out.colour_seen    = res.colour_seen;
    assign o_out.last_result    = res.last_result;

endmodule

### bench/ansi_color_utf8_cell_splitter_checker.sv
`timescale 1ns / 1ps

module ansi_color_utf8_cell_splitter_checker #(
    parameter int MAX_COLUMNS = acucs_pkg::MAX_COLUMNS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    acucs_in_if   i_text,
    acucs_out_if  i_cells,
    output int    o_mismatch_count,
    output int    o_results_owed
);
    import acucs_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow parser state
    t_mode       mode;
    int          number;
    bit          number_seen;
    logic [6:0]  colour;
    int          column;
    logic [31:0] partial;
    int          cell_need;
    int          cell_got;
    int          widest;
    bit          colour_flag;

    t_result     owed_results[$];
    t_result     step_results[$];
    int          mismatches;

    function automatic bit sgr_foreground(input int n);
        return (n >= FG_LOW_FIRST && n <= FG_LOW_LAST) || n == FG_DEFAULT ||
               (n >= FG_HIGH_FIRST && n <= FG_HIGH_LAST);
    endfunction

    function automatic int utf8_span(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 1;
        endcase
    endfunction

    function automatic string result_text(input t_result r);
        return $sformatf({"kind=%0d bytes=%08h len=%0d colour=%0d col=%0d ",
                          "count=%0d widest=%0d seen=%0d last=%0d"},
                         r.item_kind, r.cell_bytes, r.cell_length, r.cell_colour,
                         r.cell_column, r.row_cell_count, r.widest_row, r.colour_seen,
                         r.last_result);
    endfunction

    // Clear everything that a row end clears
    task automatic restart_row();
        mode        = MODE_TEXT;
        number      = 0;
        number_seen = 1'b0;
        colour      = COLOUR_DEFAULT;
        column      = 0;
        partial     = '0;
        cell_need   = 0;
        cell_got    = 0;
    endtask

    // Emit one character cell at the current column
    task automatic push_cell(input logic [31:0] bytes, input int len);
        t_result r;
        r             = '0;
        r.item_kind   = KIND_CELL;
        r.cell_bytes  = bytes;
        r.cell_length = len[2:0];
        r.cell_colour = colour;
        r.cell_column = column[6:0];
        step_results.push_back(r);
        column++;
        mode      = MODE_TEXT;
        partial   = '0;
        cell_need = 0;
        cell_got  = 0;
    endtask

    // Apply the closing number of an escape sequence
    task automatic close_sgr();
        if (number_seen) begin
            if (sgr_foreground(number)) colour = number[6:0];
            else if (number == 0) colour = COLOUR_DEFAULT;
        end
        if (colour != COLOUR_DEFAULT) colour_flag = 1'b1;
        number      = 0;
        number_seen = 1'b0;
        mode        = MODE_TEXT;
    endtask

    // Advance the parser by one text byte; a lone escape replays the byte as text
    task automatic take_byte(input logic [7:0] b);
        bit again;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            if (column < MAX_COLUMNS) begin
                case (mode)
                    MODE_TEXT: begin
                        if (b == ESC_BYTE) begin
                            mode = MODE_ESC;
                        end else begin
                            partial   = {24'd0, b};
                            cell_got  = 1;
                            cell_need = utf8_span(b);
                            if (cell_need == 1) push_cell(partial, 1);
                            else mode = MODE_CELL;
                        end
                    end
                    MODE_ESC: begin
                        if (b == OPEN_BRACKET) begin
                            mode        = MODE_SEQ;
                            number      = 0;
                            number_seen = 1'b0;
                        end else begin
                            push_cell({24'd0, ESC_BYTE}, 1);
                            again = 1'b1;
                        end
                    end
                    MODE_SEQ: begin
                        if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
                            number = number * 10 + int'(b - DIGIT_ZERO);
                            if (number > NUM_SAT) number = NUM_SAT;
                            number_seen = 1'b1;
                        end else if (b == SEMICOLON) begin
                            if (number_seen) begin
                                if (sgr_foreground(number)) colour = number[6:0];
                                else if (number == 0 || number == SGR_NORMAL)
                                    colour = COLOUR_DEFAULT;
                            end
                            number      = 0;
                            number_seen = 1'b0;
                        end else begin
                            close_sgr();
                        end
                    end
                    default: begin
                        if (cell_got < 4) begin
                            partial = partial | (32'(b) << (8 * cell_got));
                            cell_got++;
                        end
                        if (cell_got >= cell_need) push_cell(partial, cell_got);
                    end
                endcase
            end
        end
    endtask

    // Work out the results of one input transaction and queue them
    task automatic predict_cells(input logic [7:0] b, input logic row_end,
                                 input logic picture);
        t_result s;
        step_results.delete();
        if (picture) widest = 0;
        if (!row_end) begin
            take_byte(b);
        end else begin
            case (mode)
                MODE_ESC:  push_cell({24'd0, ESC_BYTE}, 1);
                MODE_CELL: push_cell(partial, cell_got);
                MODE_SEQ:  close_sgr();
                default: ;
            endcase
            if (column > widest) widest = column;
            s                = '0;
            s.item_kind      = KIND_SUMMARY;
            s.row_cell_count = column[7:0];
            s.widest_row     = widest[7:0];
            s.colour_seen    = colour_flag;
            step_results.push_back(s);
            restart_row();
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_result = 1'b1;
        foreach (step_results[k]) owed_results.push_back(step_results[k]);
    endtask

    // Compare each result transaction, then predict from each input transaction
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            restart_row();
            widest      = 0;
            colour_flag = 1'b0;
            owed_results.delete();
        end else begin
            if (i_cells.valid && i_cells.ready) begin
                got.item_kind      = i_cells.item_kind;
                got.cell_bytes     = i_cells.cell_bytes;
                got.cell_length    = i_cells.cell_length;
                got.cell_colour    = i_cells.cell_colour;
                got.cell_column    = i_cells.cell_column;
                got.row_cell_count = i_cells.row_cell_count;
                got.widest_row     = i_cells.widest_row;
                got.colour_seen    = i_cells.colour_seen;
                got.last_result    = i_cells.last_result;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result: %s", $time, result_text(got));
                end else begin
                    want = owed_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                                     result_text(want), result_text(got));
                    end
                end
            end
            if (i_text.valid && i_text.ready)
                predict_cells(i_text.text_byte, i_text.is_row_end, i_text.new_picture);
        end
        o_mismatch_count <= mismatches;
        o_results_owed   <= owed_results.size();
    end

endmodule

### bench/ansi_color_utf8_cell_splitter_top_test.sv
`timescale 1ns / 1ps

module ansi_color_utf8_cell_splitter_top_test;
    import acucs_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int TAIL_CYCLES  = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    acucs_in_if  text_ch ();
    acucs_out_if cell_ch ();

    int mismatches;
    int results_owed;
    int src_gap_pct  = 14;
    int sink_gap_pct = 65;
    int items_sent   = 0;
    int cycle_count  = 0;
    bit picture_next = 1'b0;

    always #2 i_clk = ~i_clk;

    ansi_color_utf8_cell_splitter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_ch),
        .o_out   (cell_ch)
    );

    ansi_color_utf8_cell_splitter_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text           (text_ch),
        .i_cells          (cell_ch),
        .o_mismatch_count (mismatches),
        .o_results_owed   (results_owed)
    );

    // Stall the result channel at random
    always @(posedge i_clk) begin
        cell_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
    end

    // Give up after the cycle limit
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Offer one transaction after a random gap and hold it until taken
    task automatic send_item(input logic [7:0] b, input logic row_end);
        while ($urandom_range(99) < src_gap_pct) begin
            text_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.is_row_end  <= row_end;
        text_ch.new_picture <= picture_next || ($urandom_range(63) == 0);
        picture_next = 1'b0;
        @(posedge i_clk);
        while (!text_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_number(input int n);
        string digits;
        digits = $sformatf("%0d", n);
        for (int i = 0; i < digits.len(); i++) send_item(digits[i], 1'b0);
    endtask

    // Multi-byte character, complete or cut short
    task automatic send_utf8(input bit complete);
        int         len;
        int         tail;
        logic [7:0] lead;
        len = $urandom_range(2, 4);
        case (len)
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        send_item(lead, 1'b0);
        tail = complete ? len - 1 : $urandom_range(0, len - 2);
        repeat (tail) begin
            if ($urandom_range(7) == 0) send_item(8'($urandom), 1'b0);
            else send_item({2'b10, 6'($urandom)}, 1'b0);
        end
    endtask

    // Escape sequence with random parameters and a random terminator, sometimes none
    task automatic send_sgr();
        int params;
        int pick;
        send_item(ESC_BYTE, 1'b0);
        send_item(OPEN_BRACKET, 1'b0);
        params = $urandom_range(0, 3);
        for (int p = 0; p < params; p++) begin
            if (p > 0) send_item(SEMICOLON, 1'b0);
            pick = $urandom_range(9);
            case (pick)
                0, 1:    send_number($urandom_range(FG_LOW_FIRST, FG_LOW_LAST));
                2:       send_number(FG_DEFAULT);
                3:       send_number($urandom_range(FG_HIGH_FIRST, FG_HIGH_LAST));
                4:       send_number(COLOUR_DEFAULT);
                5:       send_number(SGR_NORMAL);
                6:       send_number($urandom_range(0, 127));
                7:       send_number($urandom_range(100, 99999));
                default: ;
            endcase
        end
        pick = $urandom_range(9);
        if (pick < 7) send_item("m", 1'b0);
        else if (pick < 9) send_item(8'($urandom), 1'b0);
    endtask

    // One row of mostly well-formed text, now and then past the column limit
    task automatic random_row();
        int tokens;
        int pick;
        if ($urandom_range(5) == 0) picture_next = 1'b1;
        tokens = ($urandom_range(39) == 0) ? $urandom_range(130, 180) : $urandom_range(0, 16);
        repeat (tokens) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_item(8'($urandom_range(32, 126)), 1'b0);
            end else if (pick < 55) begin
                send_utf8(1'b1);
            end else if (pick < 75) begin
                send_sgr();
            end else if (pick < 82) begin
                send_item(ESC_BYTE, 1'b0);
                send_item(8'($urandom), 1'b0);
            end else if (pick < 92) begin
                send_item(8'($urandom), 1'b0);
            end else if (pick < 97) begin
                send_utf8(1'b0);
            end else begin
                send_item(ESC_BYTE, 1'b0);
            end
        end
        send_item(8'($urandom), 1'b1);
    endtask

    initial begin
        int target;
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= '0;
        text_ch.is_row_end  <= 1'b0;
        text_ch.new_picture <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, colour by separator, two-byte cell, lone escape,
        // normal-intensity closer, early row end, row end inside a sequence
        picture_next = 1'b1;
        send_item("A", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(ESC_BYTE, 1'b0);
        send_item(OPEN_BRACKET, 1'b0);
        send_item("9", 1'b0);
        send_item("7", 1'b0);
        send_item(SEMICOLON, 1'b0);
        send_item(8'hC3, 1'b0);
        send_item(8'hA9, 1'b0);
        send_item(ESC_BYTE, 1'b0);
        send_item("x", 1'b0);
        send_item(ESC_BYTE, 1'b0);
        send_item(OPEN_BRACKET, 1'b0);
        send_item("2", 1'b0);
        send_item("2", 1'b0);
        send_item("m", 1'b0);
        send_item(8'hE2, 1'b0);
        send_item(8'h82, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(ESC_BYTE, 1'b0);
        send_item(OPEN_BRACKET, 1'b0);
        send_item("3", 1'b0);
        send_item(8'hFF, 1'b1);

        // Random rows in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_gap_pct = 14; sink_gap_pct = 65; end
                1:       begin src_gap_pct = 65; sink_gap_pct = 14; end
                default: begin src_gap_pct = 0;  sink_gap_pct = 0;  end
            endcase
            target = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < target) random_row();
        end

        // Drain the result channel
        text_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
